@@ src/drgs_pkg.sv @@
// Shared types, constants and codes for the rectangle and glyph stream block.
package drgs_pkg;

    // Side clamp for rectangle requests
    localparam int MAX_SIDE  = 480;
    localparam int SIDE_W    = 9;
    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 16;
    localparam int REP_W     = 18;
    localparam int GLYPH_MAX = 255;

    // Display command codes
    localparam logic [COORD_W-1:0] CMD_COLUMN = 16'h002A;
    localparam logic [COORD_W-1:0] CMD_ROW    = 16'h002B;
    localparam logic [COORD_W-1:0] CMD_RAMWR  = 16'h002C;

    // First pixel of a bitmap byte
    localparam logic [7:0] TOP_BIT = 8'h80;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Config registers
    localparam logic [1:0] REG_FONT_TOP    = 2'd0;
    localparam logic [1:0] REG_FONT_BOTTOM = 2'd1;
    localparam logic [1:0] REG_FONT_HEIGHT = 2'd2;

    localparam logic [7:0] FONT_TOP_RST    = 8'hF0;
    localparam logic [7:0] FONT_BOTTOM_RST = 8'h04;
    localparam logic [7:0] FONT_HEIGHT_RST = 8'd20;

    typedef enum logic [1:0] {
        ACT_RECT  = 2'd0,
        ACT_FIRST = 2'd1,
        ACT_NEXT  = 2'd2,
        ACT_BYTE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        JOB_RECT  = 2'd0,
        JOB_GLYPH = 2'd1,
        JOB_BYTE  = 2'd2
    } job_kind_t;

    // Header word slots of a rectangle or glyph
    localparam logic [3:0] SLOT_COL_CMD = 4'd0;
    localparam logic [3:0] SLOT_X       = 4'd1;
    localparam logic [3:0] SLOT_X_END   = 4'd2;
    localparam logic [3:0] SLOT_ROW_CMD = 4'd3;
    localparam logic [3:0] SLOT_Y       = 4'd4;
    localparam logic [3:0] SLOT_Y_END   = 4'd5;
    localparam logic [3:0] SLOT_RAMWR   = 4'd6;
    localparam logic [3:0] SLOT_FILL    = 4'd7;
    localparam logic [3:0] SLOT_ROWS    = 4'd8;
    localparam logic [3:0] SLOT_BELOW   = 4'd9;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HDR,
        BK_LEAD,
        BK_PIXEL,
        BK_TRAIL,
        BK_BELOW
    } bk_state_t;

    // One classified request, front to back
    typedef struct packed {
        job_kind_t            kind;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   x_end;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   y_end;
        logic [COLOR_W-1:0]   c0;        // fill or foreground
        logic [COLOR_W-1:0]   c1;        // background
        logic [REP_W-1:0]     run0;      // fill area or run above
        logic [REP_W-1:0]     run1;      // rows of an empty glyph
        logic [15:0]          run2;      // run below
        logic [7:0]           gw;
        logic [7:0]           gh;
        logic [7:0]           lpad;
        logic [8:0]           rpad;
        logic                 zero_glyph;
        logic                 eot;
        logic [7:0]           data;
    } job_t;

    typedef struct packed {
        logic                 is_command;
        logic [COORD_W-1:0]   value;
        logic [REP_W-1:0]     repeat_res;
    } gen_word_t;

    typedef struct packed {
        gen_word_t            w;
        logic                 release_select;
        logic                 last;
    } out_word_t;

endpackage

@@ src/drgs_front.sv @@
// Front end: accepts requests, holds font config, cursor and colors, builds jobs.
module drgs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [15:0]                   pos_x,
    input  logic [15:0]                   pos_y,
    input  logic [8:0]                    width,
    input  logic [8:0]                    height,
    input  logic [15:0]                   color,
    input  logic [15:0]                   back_color,
    input  logic [7:0]                    advance,
    input  logic signed [7:0]             offset_x,
    input  logic signed [7:0]             offset_y,
    input  logic [7:0]                    data_byte,
    input  logic                          last_char,
    input  logic                          wr_en,
    input  logic [1:0]                    wr_index,
    input  logic [7:0]                    wr_data,
    input  logic                          q_full,
    output logic                          push,
    output drgs_pkg::job_t                push_job
);

    logic [7:0]  font_top_reg;
    logic [7:0]  font_bottom_reg;
    logic [7:0]  font_height_reg;
    logic [15:0] cursor_x_reg;
    logic [15:0] cursor_y_reg;
    logic [15:0] fore_reg;
    logic [15:0] back_reg;

    logic        first;
    logic        glyph;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] fg;
    logic [15:0] bg;

    logic [drgs_pkg::SIDE_W-1:0] wc;
    logic [drgs_pkg::SIDE_W-1:0] hc;
    logic [drgs_pkg::REP_W-1:0]  area;

    logic [7:0]          gw;
    logic [7:0]          gh;
    logic signed [9:0]   dtop;
    logic signed [19:0]  dtop_x;
    logic signed [19:0]  adv_x;
    logic signed [19:0]  above;
    logic signed [10:0]  below_s;
    logic [7:0]          below;
    logic signed [10:0]  rpad_s;
    logic [8:0]          rpad;
    logic [7:0]          lpad;
    logic [9:0]          row;
    logic [drgs_pkg::REP_W-1:0] run0_g;
    logic [drgs_pkg::REP_W-1:0] run1_g;
    logic [15:0]         run2_g;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    assign first = (action == drgs_pkg::ACT_FIRST);
    assign glyph = first || (action == drgs_pkg::ACT_NEXT);
    assign cx    = first ? pos_x      : cursor_x_reg;
    assign cy    = first ? pos_y      : cursor_y_reg;
    assign fg    = first ? color      : fore_reg;
    assign bg    = first ? back_color : back_reg;

    // rectangle
    assign wc   = (int'(width)  > drgs_pkg::MAX_SIDE) ?
                  drgs_pkg::SIDE_W'(drgs_pkg::MAX_SIDE) : width;
    assign hc   = (int'(height) > drgs_pkg::MAX_SIDE) ?
                  drgs_pkg::SIDE_W'(drgs_pkg::MAX_SIDE) : height;
    // two 9-bit sides cannot pass the 18-bit repeat limit
    assign area = {9'd0, wc} * {9'd0, hc};

    // glyph cell
    assign gw = (int'(width)  > drgs_pkg::GLYPH_MAX) ? 8'(drgs_pkg::GLYPH_MAX) : width[7:0];
    assign gh = (int'(height) > drgs_pkg::GLYPH_MAX) ? 8'(drgs_pkg::GLYPH_MAX) : height[7:0];

    assign dtop   = {{2{offset_y[7]}}, offset_y} - {{2{font_top_reg[7]}}, font_top_reg};
    assign dtop_x = 20'(dtop);
    assign adv_x  = {12'd0, advance};
    assign above  = dtop_x * adv_x;
    assign run0_g = (above > 20'sd0) ? above[drgs_pkg::REP_W-1:0] : '0;

    assign below_s = {{3{font_bottom_reg[7]}}, font_bottom_reg}
                   - ({{3{offset_y[7]}}, offset_y} + {3'd0, gh});
    assign below   = (below_s > 11'sd0) ? below_s[7:0] : 8'd0;
    assign run2_g  = {8'd0, below} * {8'd0, advance};

    assign rpad_s = {3'd0, advance} - ({{3{offset_x[7]}}, offset_x} + {3'd0, gw});
    assign rpad   = (rpad_s > 11'sd0) ? rpad_s[8:0] : 9'd0;
    assign lpad   = (offset_x > 8'sd0) ? offset_x : 8'd0;
    assign row    = {2'd0, lpad} + {1'b0, rpad};
    assign run1_g = {8'd0, row} * {10'd0, gh};

    always_comb
    begin
        push_job      = '0;
        push_job.kind = drgs_pkg::JOB_BYTE;
        push_job.data = data_byte;
        unique case (action)
            drgs_pkg::ACT_RECT:
            begin
                push_job.kind  = drgs_pkg::JOB_RECT;
                push_job.x     = pos_x;
                push_job.x_end = pos_x + {7'd0, wc} - 16'd1;
                push_job.y     = pos_y;
                push_job.y_end = pos_y + {7'd0, hc} - 16'd1;
                push_job.c0    = color;
                push_job.run0  = area;
            end
            drgs_pkg::ACT_FIRST, drgs_pkg::ACT_NEXT:
            begin
                push_job.kind       = drgs_pkg::JOB_GLYPH;
                push_job.x          = cx;
                push_job.x_end      = cx + {8'd0, advance} - 16'd1;
                push_job.y          = cy;
                push_job.y_end      = cy + {8'd0, font_height_reg} - 16'd1;
                push_job.c0         = fg;
                push_job.c1         = bg;
                push_job.run0       = run0_g;
                push_job.run1       = run1_g;
                push_job.run2       = run2_g;
                push_job.gw         = gw;
                push_job.gh         = gh;
                push_job.lpad       = lpad;
                push_job.rpad       = rpad;
                push_job.zero_glyph = (gw == 8'd0) || (gh == 8'd0);
                push_job.eot        = last_char;
            end
            default:
            begin
                push_job.kind = drgs_pkg::JOB_BYTE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_top_reg    <= drgs_pkg::FONT_TOP_RST;
            font_bottom_reg <= drgs_pkg::FONT_BOTTOM_RST;
            font_height_reg <= drgs_pkg::FONT_HEIGHT_RST;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            fore_reg        <= '0;
            back_reg        <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    drgs_pkg::REG_FONT_TOP:    font_top_reg    <= wr_data;
                    drgs_pkg::REG_FONT_BOTTOM: font_bottom_reg <= wr_data;
                    drgs_pkg::REG_FONT_HEIGHT: font_height_reg <= wr_data;
                    default: ;
                endcase
            end
            if (push && glyph)
            begin
                cursor_x_reg <= cx + {8'd0, advance};
                cursor_y_reg <= cy;
                fore_reg     <= fg;
                back_reg     <= bg;
            end
        end
    end

endmodule

@@ src/drgs_queue.sv @@
// Short job queue that decouples the front end from the word sequencer.
module drgs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  drgs_pkg::job_t  push_job,
    input  logic            pop,
    output drgs_pkg::job_t  head,
    output logic            full,
    output logic            nonempty
);

    drgs_pkg::job_t                   slots [drgs_pkg::QUEUE_DEPTH];
    logic [drgs_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [drgs_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [drgs_pkg::QUEUE_CW-1:0]    count_reg;

    assign head     = slots[rd_ptr_reg];
    assign full     = (count_reg == drgs_pkg::QUEUE_CW'(drgs_pkg::QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == drgs_pkg::QUEUE_AW'(drgs_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == drgs_pkg::QUEUE_AW'(drgs_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ src/drgs_back.sv @@
// Back end: word sequencer for headers and bitmap pixels, end-mark hold and output register.
module drgs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_nonempty,
    input  drgs_pkg::job_t               q_job,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         is_command,
    output logic [15:0]                  value,
    output logic [17:0]                  repeat_res,
    output logic                         release_select,
    output logic                         last
);

    drgs_pkg::bk_state_t st_reg;
    drgs_pkg::bk_state_t st_next;
    drgs_pkg::bk_state_t cont_st;
    logic [3:0]          slot_reg;
    logic [3:0]          slot_next;
    logic [3:0]          cont_slot;
    drgs_pkg::job_t      job_reg;

    // glyph context
    logic        g_active_reg;
    logic        g_eot_reg;
    logic [15:0] g_fore_reg;
    logic [15:0] g_back_reg;
    logic [7:0]  g_gw_reg;
    logic [7:0]  g_rows_reg;
    logic [7:0]  g_col_reg;
    logic [7:0]  g_lpad_reg;
    logic [8:0]  g_rpad_reg;
    logic [15:0] g_below_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  pix_reg;

    // hold stage keeps the newest word until it is known whether it ends its word group
    logic                   hold_valid_reg;
    drgs_pkg::gen_word_t    hold_word_reg;
    logic                   hold_end_reg;
    logic                   hold_rel_reg;
    logic                   out_valid_reg;
    drgs_pkg::out_word_t    out_word_reg;

    logic                   out_take;
    logic                   run;
    logic                   hold_move;
    logic                   gen_valid;
    drgs_pkg::gen_word_t    gen_word;
    logic                   done;
    logic                   done_rel;
    logic                   do_pixel;
    logic                   px_step;
    logic                   row_step;
    logic                   glyph_off;
    logic                   g_active_step;
    logic                   row_end;

    assign out_take  = !out_valid_reg || !out_stall;
    assign run       = !hold_valid_reg || out_take;
    assign hold_move = hold_valid_reg && out_take && (gen_valid || hold_end_reg);
    assign row_end   = ({1'b0, g_col_reg} + 9'd1) >= {1'b0, g_gw_reg};

    // step decisions and generated word
    always_comb
    begin
        gen_valid = 1'b0;
        gen_word  = '0;
        done      = 1'b0;
        done_rel  = 1'b0;
        do_pixel  = 1'b0;
        px_step   = 1'b0;
        row_step  = 1'b0;
        glyph_off = 1'b0;
        cont_st   = st_reg;
        cont_slot = slot_reg;
        if (run)
        begin
            unique case (st_reg)
                drgs_pkg::BK_IDLE: ;
                drgs_pkg::BK_HDR:
                begin
                    cont_slot           = slot_reg + 4'd1;
                    gen_word.repeat_res = 18'd1;
                    unique case (slot_reg)
                        drgs_pkg::SLOT_COL_CMD:
                        begin
                            gen_valid           = 1'b1;
                            gen_word.is_command = 1'b1;
                            gen_word.value      = drgs_pkg::CMD_COLUMN;
                        end
                        drgs_pkg::SLOT_X:
                        begin
                            gen_valid      = 1'b1;
                            gen_word.value = job_reg.x;
                        end
                        drgs_pkg::SLOT_X_END:
                        begin
                            gen_valid      = 1'b1;
                            gen_word.value = job_reg.x_end;
                        end
                        drgs_pkg::SLOT_ROW_CMD:
                        begin
                            gen_valid           = 1'b1;
                            gen_word.is_command = 1'b1;
                            gen_word.value      = drgs_pkg::CMD_ROW;
                        end
                        drgs_pkg::SLOT_Y:
                        begin
                            gen_valid      = 1'b1;
                            gen_word.value = job_reg.y;
                        end
                        drgs_pkg::SLOT_Y_END:
                        begin
                            gen_valid      = 1'b1;
                            gen_word.value = job_reg.y_end;
                        end
                        drgs_pkg::SLOT_RAMWR:
                        begin
                            gen_valid           = 1'b1;
                            gen_word.is_command = 1'b1;
                            gen_word.value      = drgs_pkg::CMD_RAMWR;
                        end
                        drgs_pkg::SLOT_FILL:
                        begin
                            gen_word.repeat_res = job_reg.run0;
                            if (job_reg.kind == drgs_pkg::JOB_RECT)
                            begin
                                // zero area still sends its fill run
                                gen_valid      = 1'b1;
                                gen_word.value = job_reg.c0;
                                done           = 1'b1;
                                done_rel       = 1'b1;
                            end
                            else
                            begin
                                gen_valid      = (job_reg.run0 != '0);
                                gen_word.value = job_reg.c1;
                                done           = !job_reg.zero_glyph;
                            end
                        end
                        drgs_pkg::SLOT_ROWS:
                        begin
                            gen_valid           = (job_reg.run1 != '0);
                            gen_word.value      = job_reg.c1;
                            gen_word.repeat_res = job_reg.run1;
                        end
                        drgs_pkg::SLOT_BELOW:
                        begin
                            gen_valid           = (job_reg.run2 != '0);
                            gen_word.value      = job_reg.c1;
                            gen_word.repeat_res = {2'd0, job_reg.run2};
                            done                = 1'b1;
                            done_rel            = job_reg.eot;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
                drgs_pkg::BK_LEAD:
                begin
                    if (g_col_reg == 8'd0 && g_lpad_reg != 8'd0)
                    begin
                        gen_valid           = 1'b1;
                        gen_word.value      = g_back_reg;
                        gen_word.repeat_res = {10'd0, g_lpad_reg};
                        cont_st             = drgs_pkg::BK_PIXEL;
                    end
                    else
                    begin
                        do_pixel = 1'b1;
                    end
                end
                drgs_pkg::BK_PIXEL:
                begin
                    do_pixel = 1'b1;
                end
                drgs_pkg::BK_TRAIL:
                begin
                    gen_valid           = 1'b1;
                    gen_word.value      = g_back_reg;
                    gen_word.repeat_res = {9'd0, g_rpad_reg};
                    if (g_rows_reg == 8'd0)
                    begin
                        if (g_below_reg != 16'd0)
                        begin
                            cont_st = drgs_pkg::BK_BELOW;
                        end
                        else
                        begin
                            glyph_off = 1'b1;
                            done      = 1'b1;
                            done_rel  = g_eot_reg;
                        end
                    end
                    else if (pix_reg == 4'd8)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        cont_st = drgs_pkg::BK_LEAD;
                    end
                end
                drgs_pkg::BK_BELOW:
                begin
                    gen_valid           = 1'b1;
                    gen_word.value      = g_back_reg;
                    gen_word.repeat_res = {2'd0, g_below_reg};
                    glyph_off           = 1'b1;
                    done                = 1'b1;
                    done_rel            = g_eot_reg;
                end
                default: ;
            endcase

            if (do_pixel)
            begin
                gen_valid           = 1'b1;
                gen_word.value      = ((byte_reg & drgs_pkg::TOP_BIT) != 8'd0) ?
                                      g_fore_reg : g_back_reg;
                gen_word.repeat_res = 18'd1;
                px_step             = 1'b1;
                cont_st             = drgs_pkg::BK_LEAD;
                if (row_end)
                begin
                    row_step = 1'b1;
                end
                priority if (row_end && g_rpad_reg != 9'd0)
                begin
                    cont_st = drgs_pkg::BK_TRAIL;
                end
                else if (row_end && g_rows_reg == 8'd1)
                begin
                    if (g_below_reg != 16'd0)
                    begin
                        cont_st = drgs_pkg::BK_BELOW;
                    end
                    else
                    begin
                        glyph_off = 1'b1;
                        done      = 1'b1;
                        done_rel  = g_eot_reg;
                    end
                end
                else if (pix_reg == 4'd7)
                begin
                    done = 1'b1;
                end
                else
                begin
                    cont_st = drgs_pkg::BK_LEAD;
                end
            end
        end
    end

    assign pop           = run && q_nonempty && ((st_reg == drgs_pkg::BK_IDLE) || done);
    assign g_active_step = glyph_off ? 1'b0 : g_active_reg;

    // next state
    always_comb
    begin
        st_next   = cont_st;
        slot_next = cont_slot;
        if (pop)
        begin
            slot_next = drgs_pkg::SLOT_COL_CMD;
            unique case (q_job.kind)
                drgs_pkg::JOB_RECT,
                drgs_pkg::JOB_GLYPH: st_next = drgs_pkg::BK_HDR;
                drgs_pkg::JOB_BYTE:  st_next = g_active_step ? drgs_pkg::BK_LEAD :
                                                               drgs_pkg::BK_IDLE;
                default:             st_next = drgs_pkg::BK_IDLE;
            endcase
        end
        else if (done)
        begin
            st_next = drgs_pkg::BK_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= drgs_pkg::BK_IDLE;
            slot_reg       <= drgs_pkg::SLOT_COL_CMD;
            g_active_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            hold_end_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            slot_reg <= slot_next;

            g_active_reg <= g_active_step;
            if (pop && q_job.kind == drgs_pkg::JOB_RECT)
            begin
                g_active_reg <= 1'b0;
            end
            else if (pop && q_job.kind == drgs_pkg::JOB_GLYPH)
            begin
                g_active_reg <= !q_job.zero_glyph;
            end

            if (gen_valid)
            begin
                hold_valid_reg <= 1'b1;
                hold_end_reg   <= done;
            end
            else if (done)
            begin
                hold_end_reg <= 1'b1;
            end
            else if (hold_move)
            begin
                hold_valid_reg <= 1'b0;
                hold_end_reg   <= 1'b0;
            end

            if (hold_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (px_step)
        begin
            byte_reg <= byte_reg << 1;
            pix_reg  <= pix_reg + 4'd1;
            g_col_reg <= row_step ? 8'd0 : g_col_reg + 8'd1;
            if (row_step)
            begin
                g_rows_reg <= g_rows_reg - 8'd1;
            end
        end
        if (pop)
        begin
            job_reg <= q_job;
            if (q_job.kind == drgs_pkg::JOB_BYTE)
            begin
                byte_reg <= q_job.data;
                pix_reg  <= 4'd0;
            end
            if (q_job.kind == drgs_pkg::JOB_GLYPH)
            begin
                g_eot_reg   <= q_job.eot;
                g_fore_reg  <= q_job.c0;
                g_back_reg  <= q_job.c1;
                g_gw_reg    <= q_job.gw;
                g_rows_reg  <= q_job.gh;
                g_col_reg   <= 8'd0;
                g_lpad_reg  <= q_job.lpad;
                g_rpad_reg  <= q_job.rpad;
                g_below_reg <= q_job.run2;
            end
        end
        if (gen_valid)
        begin
            hold_word_reg <= gen_word;
        end
        if (done)
        begin
            hold_rel_reg <= done_rel;
        end
        if (hold_move)
        begin
            out_word_reg.w              <= hold_word_reg;
            out_word_reg.last           <= hold_end_reg;
            out_word_reg.release_select <= hold_end_reg && hold_rel_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_command     = out_word_reg.w.is_command;
    assign value          = out_word_reg.w.value;
    assign repeat_res     = out_word_reg.w.repeat_res;
    assign release_select = out_word_reg.release_select;
    assign last           = out_word_reg.last;

endmodule

@@ src/display_rect_glyph_stream.sv @@
// Top level: rectangle and glyph request to display command and pixel-run word stream.
// Path: the first result word of a request passes the job queue, the sequencer state, the
//   hold stage and the output register; a held word moves on with the next word or its end mark.
// Throughput: a request is taken each cycle while the 4-entry job queue has room; the word
//   sequencer sends at most one word per cycle while the output is not stalled: 8 for a rectangle,
//   7 to 10 for a glyph header, up to 25 for a bitmap byte (one per pixel plus padding runs).
// Reset: rst_n is asynchronous, active low; it empties the queue and output stages,
//   clears cursor and colors and loads the font registers with their defaults.
module display_rect_glyph_stream (
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            action,
    input  logic [15:0]           pos_x,
    input  logic [15:0]           pos_y,
    input  logic [8:0]            width,
    input  logic [8:0]            height,
    input  logic [15:0]           color,
    input  logic [15:0]           back_color,
    input  logic [7:0]            advance,
    input  logic signed [7:0]     offset_x,
    input  logic signed [7:0]     offset_y,
    input  logic [7:0]            data_byte,
    input  logic                  last_char,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  is_command,
    output logic [15:0]           value,
    output logic [17:0]           repeat_res,
    output logic                  release_select,
    output logic                  last,
    // font register writes
    input  logic                  wr_en,
    input  logic [1:0]            wr_index,
    input  logic [7:0]            wr_data
);

    // front -> queue -> back
    logic            push;
    drgs_pkg::job_t  push_job;
    logic            q_full;
    logic            q_nonempty;
    logic            pop;
    drgs_pkg::job_t  q_job;

    // Front: classifies each request, works out window ends, padding and run lengths
    // (one multiply per run), and moves cursor and colors. Stalls only on a full queue.
    drgs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .width      (width),
        .height     (height),
        .color      (color),
        .back_color (back_color),
        .advance    (advance),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .data_byte  (data_byte),
        .last_char  (last_char),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Job queue: lets the front keep taking requests while the back drains a long run.
    drgs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (q_job),
        .full     (q_full),
        .nonempty (q_nonempty)
    );

    // Back: header slot walker and per-pixel bitmap walker, owns the glyph progress
    // state; the hold stage adds the end-of-request mark, the output register
    // parts it from the downstream stall.
    drgs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_nonempty     (q_nonempty),
        .q_job          (q_job),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_command     (is_command),
        .value          (value),
        .repeat_res     (repeat_res),
        .release_select (release_select),
        .last           (last)
    );

endmodule

@@ src/drgs_checker.sv @@
// Port-level checker for the result stream, bound to the top level.
module drgs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          is_command,
    input logic [drgs_pkg::COORD_W-1:0]  value,
    input logic [drgs_pkg::REP_W-1:0]    repeat_res,
    input logic                          release_select,
    input logic                          last
);

    // stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(repeat_res)
            && $stable(is_command) && $stable(last) && $stable(release_select))
        else $error("stalled result word changed");

    // release only on the closing word of a request
    a_release_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && release_select |-> last)
        else $error("release_select without last");

    // commands are single words with a known code
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_command |-> repeat_res == drgs_pkg::REP_W'(1)
            && (value == drgs_pkg::CMD_COLUMN || value == drgs_pkg::CMD_ROW
                || value == drgs_pkg::CMD_RAMWR))
        else $error("bad command word");

    // nothing offered while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("out_valid during reset");

endmodule

bind display_rect_glyph_stream drgs_checker u_drgs_checker (.*);
